// ===== rtl/bdmc_pkg.sv =====
// shared types and constants for the button debounce and multi-click unit
package bdmc_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned DEB_W   = 10;
  localparam int unsigned WIN_W   = 12;
  localparam int unsigned CLICK_W = 4;

  // register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_TARGET   = 2'd2,
    REG_ENABLE   = 2'd3
  } reg_idx_t;

  localparam logic [DEB_W-1:0]   DEB_RESET    = DEB_W'(10);
  localparam logic [WIN_W-1:0]   WIN_RESET    = WIN_W'(500);
  localparam logic [CLICK_W-1:0] TARGET_RESET = CLICK_W'(2);

  // input item kind
  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  // remembered button level
  typedef enum logic [1:0] {
    LVL_RELEASED = 2'd0,
    LVL_PRESSED  = 2'd1,
    LVL_UNKNOWN  = 2'd2
  } level_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_MULTI   = 2'd3
  } event_t;

  typedef struct packed {
    logic [DEB_W-1:0]   debounce_ticks;
    logic [WIN_W-1:0]   window_ticks;
    logic [CLICK_W-1:0] click_target;
    logic               multi_click_enable;
  } cfg_t;

endpackage

// ===== rtl/bdmc_if.sv =====
// valid/ready channel interfaces for input items and result items
interface bdmc_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic level;

  modport source (output valid, output kind, output level, input ready);
  modport sink   (input valid, input kind, input level, output ready);
endinterface

interface bdmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       toggle_state;

  modport source (output valid, output event_res, output toggle_state, input ready);
  modport sink   (input valid, input event_res, input toggle_state, output ready);
endinterface

// ===== rtl/bdmc_cfg_regs.sv =====
// apb-style configuration registers
module bdmc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bdmc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bdmc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bdmc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output bdmc_pkg::cfg_t                 cfg
);
  import bdmc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= DEB_RESET;
      cfg_r.window_ticks       <= WIN_RESET;
      cfg_r.click_target       <= TARGET_RESET;
      cfg_r.multi_click_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE: cfg_r.debounce_ticks     <= cfg_pwdata[DEB_W-1:0];
        REG_WINDOW:   cfg_r.window_ticks       <= cfg_pwdata[WIN_W-1:0];
        REG_TARGET:   cfg_r.click_target       <= cfg_pwdata[CLICK_W-1:0];
        REG_ENABLE:   cfg_r.multi_click_enable <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE: cfg_prdata = CFG_DATA_W'(cfg_r.debounce_ticks);
      REG_WINDOW:   cfg_prdata = CFG_DATA_W'(cfg_r.window_ticks);
      REG_TARGET:   cfg_prdata = CFG_DATA_W'(cfg_r.click_target);
      REG_ENABLE:   cfg_prdata = CFG_DATA_W'(cfg_r.multi_click_enable);
      default:      cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/bdmc_core.sv =====
// debounce, click counting and window state with its single-pass update
module bdmc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  bdmc_pkg::cfg_t    cfg,
  input  logic              step_en,
  input  logic              kind,
  input  logic              level,
  output bdmc_pkg::event_t  ev,
  output logic              toggle
);
  import bdmc_pkg::*;

  logic [DEB_W-1:0]   debounce_left_r, debounce_left_nxt;
  logic               settled_r, settled_nxt;
  logic [WIN_W-1:0]   window_left_r, window_left_nxt;
  logic               window_running_r, window_running_nxt;
  logic [CLICK_W-1:0] clicks_r, clicks_nxt;
  level_t             last_level_r, last_level_nxt;
  logic               toggle_r, toggle_nxt;

  logic [DEB_W-1:0] deb_len;
  logic [WIN_W-1:0] win_len;
  logic [WIN_W-1:0] win_dec;
  logic             click;

  // a zero length acts as one
  assign deb_len = (cfg.debounce_ticks == '0) ? DEB_W'(1) : cfg.debounce_ticks;
  assign win_len = (cfg.window_ticks == '0) ? WIN_W'(1) : cfg.window_ticks;
  assign win_dec = (window_left_r != '0) ? window_left_r - WIN_W'(1) : '0;
  assign click   = (last_level_r == LVL_PRESSED) && !level;

  always_comb begin
    debounce_left_nxt  = debounce_left_r;
    settled_nxt        = settled_r;
    window_left_nxt    = window_left_r;
    window_running_nxt = window_running_r;
    clicks_nxt         = clicks_r;
    last_level_nxt     = last_level_r;
    toggle_nxt         = toggle_r;
    ev                 = EV_NONE;
    unique case (kind_t'(kind))
      KIND_EDGE: begin
        debounce_left_nxt = deb_len;
        if (settled_r) begin
          last_level_nxt = level ? LVL_PRESSED : LVL_RELEASED;
          if (click) begin
            if (!window_running_r && cfg.multi_click_enable) begin
              window_left_nxt    = win_len;
              window_running_nxt = 1'b1;
            end
            if (clicks_r >= cfg.click_target) begin
              clicks_nxt = cfg.click_target;
            end else begin
              clicks_nxt = clicks_r + CLICK_W'(1);
            end
          end
          settled_nxt = 1'b0;
          ev          = level ? EV_PRESS : EV_RELEASE;
        end
      end
      KIND_TICK: begin
        if (debounce_left_r != '0) begin
          debounce_left_nxt = debounce_left_r - DEB_W'(1);
          if (debounce_left_r == DEB_W'(1)) begin
            settled_nxt = 1'b1;
          end
        end
        if (window_running_r) begin
          window_left_nxt = win_dec;
          if (win_dec == '0) begin
            if (clicks_r == cfg.click_target) begin
              ev         = EV_MULTI;
              toggle_nxt = !toggle_r;
            end
            clicks_nxt         = '0;
            window_running_nxt = 1'b0;
            last_level_nxt     = LVL_UNKNOWN;
          end
        end
      end
      default: ;
    endcase
  end

  assign toggle = toggle_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_left_r  <= '0;
      settled_r        <= 1'b1;
      window_left_r    <= '0;
      window_running_r <= 1'b0;
      clicks_r         <= '0;
      last_level_r     <= LVL_UNKNOWN;
      toggle_r         <= 1'b0;
    end else if (step_en) begin
      debounce_left_r  <= debounce_left_nxt;
      settled_r        <= settled_nxt;
      window_left_r    <= window_left_nxt;
      window_running_r <= window_running_nxt;
      clicks_r         <= clicks_nxt;
      last_level_r     <= last_level_nxt;
      toggle_r         <= toggle_nxt;
    end
  end

endmodule

// ===== rtl/button_debounce_multi_click_unit.sv =====
// top level: input register, state update and result register
// path: an accepted item passes the input register, then the result register
// throughput: one item per cycle unless the output stalls; the state update is a single
// pass between the input register and the result register, so items follow back to back
// reset: synchronous active-low rst_n clears the valid flags of both pipeline registers,
// the state and the configuration registers to their defaults; no clearing pass
module button_debounce_multi_click_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  bdmc_in_if.sink                         in_ch,
  bdmc_out_if.source                      out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bdmc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bdmc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bdmc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import bdmc_pkg::*;

  cfg_t   cfg;
  event_t ev;
  logic   toggle;

  logic   in_valid_r;
  logic   in_kind_r;
  logic   in_level_r;
  logic   out_valid_r;
  event_t out_event_r;
  logic   out_toggle_r;
  logic   adv;
  logic   in_take;

  bdmc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bdmc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (adv),
    .kind    (in_kind_r),
    .level   (in_level_r),
    .ev      (ev),
    .toggle  (toggle)
  );

  // the held item moves on when the result register is free or being emptied
  assign adv         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_kind_r  <= in_ch.kind;
      in_level_r <= in_ch.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_event_r  <= ev;
      out_toggle_r <= toggle;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_res    = out_event_r;
  assign out_ch.toggle_state = out_toggle_r;

endmodule

// ===== rtl/bdmc_checker.sv =====
// port-level checks for the button debounce unit, bound to the top level
module bdmc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_res,
  input logic       toggle_state
);
  import bdmc_pkg::*;

  logic       last_toggle_r;
  logic [1:0] inflight_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_toggle_r <= 1'b0;
      inflight_r    <= '0;
    end else begin
      if (out_acc) begin
        last_toggle_r <= toggle_state;
      end
      inflight_r <= inflight_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  // a result only exists for an item that went in
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 2'd0)
    else $error("result shown with no item in flight");

  // at most two items held inside
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r == 2'd2 && in_acc |-> out_acc)
    else $error("item accepted with both stages full");

  // the flag flips exactly on a multi-click result
  a_toggle_multi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == EV_MULTI |-> toggle_state != last_toggle_r)
    else $error("multi-click without toggle flip");

  a_toggle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != EV_MULTI |-> toggle_state == last_toggle_r)
    else $error("toggle changed without multi-click");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(toggle_state))
    else $error("stalled result changed");

endmodule

bind button_debounce_multi_click_unit bdmc_checker u_bdmc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .event_res    (out_ch.event_res),
  .toggle_state (out_ch.toggle_state)
);
